// ----- rtl/core/ftpc_pkg.sv -----
// Shared types, constants and match functions for the FTP data payload classifier.
// Used by every module under rtl/core; depends on nothing else.
package ftpc_pkg;

  localparam int HEAD_BYTES  = 10;
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  localparam int WORD_LEN = 6;
  localparam int PROG_W   = $clog2(WORD_LEN);

  localparam int NUM_SIGS    = 36;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int REG_ADDR_W  = 2;
  localparam int PADDR_W     = REG_ADDR_W + 2;
  localparam int PDATA_W     = 32;

  localparam logic [REG_ADDR_W-1:0] REG_DATA_PORT   = 2'd0;
  localparam logic [REG_ADDR_W-1:0] REG_MAGIC_MIN   = 2'd1;
  localparam logic [REG_ADDR_W-1:0] REG_LISTING_MIN = 2'd2;

  localparam logic [CFG_WIDTH-1:0] RST_DATA_PORT   = 16'd20;
  localparam logic [CFG_WIDTH-1:0] RST_MAGIC_MIN   = 16'd256;
  localparam logic [CFG_WIDTH-1:0] RST_LISTING_MIN = 16'd11;

  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_W    = 8'h77;
  localparam logic [7:0] CH_X    = 8'h78;

  localparam logic [31:0] XML_LEAD = 32'h3C3F786D;

  typedef logic [HEAD_BYTES-1:0][7:0] head_t;
  typedef logic [COUNT_WIDTH-1:0]     count_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] data_port;
    logic [CFG_WIDTH-1:0] magic_min_length;
    logic [CFG_WIDTH-1:0] listing_min_length;
  } cfg_t;

  typedef struct packed {
    logic flow_start;
    logic magic_hit;
    logic listing_hit;
    logic port_hit;
  } pkt_rec_t;

  typedef enum logic [1:0] {
    REASON_NONE    = 2'd0,
    REASON_MAGIC   = 2'd1,
    REASON_LISTING = 2'd2,
    REASON_PORT    = 2'd3
  } reason_t;

  localparam logic [31:0] SIG_WORD [NUM_SIGS] = '{
    32'h52494646, 32'h4F676753, 32'h52617221, 32'h47494638,
    32'h25504446, 32'h3C68746D, 32'h3C21444F, 32'h664C6143,
    32'h577A5061, 32'h54415045, 32'h213C6172, 32'h53504649,
    32'h41424946, 32'h2E74656D, 32'h2E697465, 32'h2E6C6566,
    32'h504B0304, 32'h000001BA, 32'h1A45DFA3, 32'hFFD80000,
    32'h89504E47, 32'h0A3C2144, 32'h377ABCAF, 32'h1F8B0800,
    32'h3C3F7068, 32'h49443303, 32'hFFFB90C0, 32'hEDABEEDB,
    32'h464C5601, 32'hD0CF11E0, 32'h3C254020, 32'h3C212D2D,
    32'h425A6839, 32'h3C636600, 32'h3C436600, 32'h3C697120
  };

  localparam logic [31:0] SIG_MASK [NUM_SIGS] = '{
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFF0000,
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFF00,
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
    32'hFFFFFFFF, 32'hFFFFFF00, 32'hFFFFFF00, 32'hFFFFFFFF
  };

  function automatic logic [7:0] word_char(logic [PROG_W-1:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h6A;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h62;
      3'd3:    c = 8'h62;
      3'd4:    c = 8'h65;
      3'd5:    c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic magic_sig_hit(logic [31:0] lead);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_SIGS; i++) begin
      if ((lead & SIG_MASK[i]) == SIG_WORD[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic listing_hit(head_t h);
    logic ok;
    ok = (h[0] == CH_DASH) || (h[0] == CH_D);
    for (int t = 0; t < 3; t++) begin
      ok = ok & (h[1 + 3*t] inside {CH_DASH, CH_R})
              & (h[2 + 3*t] inside {CH_DASH, CH_W})
              & (h[3 + 3*t] inside {CH_DASH, CH_X});
    end
    return ok;
  endfunction

endpackage

// ----- rtl/core/ftpc_front.sv -----
// Front end: takes payload beats, keeps head bytes, length and word matcher state,
// and on the last beat emits a packet record of test hits. Depends on ftpc_pkg.
module ftpc_front import ftpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           payload_byte,
  input  logic                 last_byte,
  input  logic                 is_tcp,
  input  logic [15:0]          source_port,
  input  logic [15:0]          dest_port,
  input  logic                 flow_start,
  input  cfg_t                 cfg,
  output logic                 rec_valid,
  output pkt_rec_t             rec
);

  head_t             head_r, head_nxt;
  count_t            count_r, count_nxt;
  logic [PROG_W-1:0] prog_r, prog_nxt;
  logic              word_seen_r, word_seen_nxt;
  logic              zero_seen_r, zero_seen_nxt;
  logic [31:0]       lead;
  logic              magic_len_ok;
  logic              listing_len_ok;

  always_comb begin
    head_nxt = head_r;
    for (int i = 0; i < HEAD_BYTES; i++) begin
      if (count_r == COUNT_WIDTH'(i)) begin
        head_nxt[i] = payload_byte;
      end
    end
    count_nxt = (&count_r) ? count_r : count_r + 1'b1;

    zero_seen_nxt = zero_seen_r | (payload_byte == 8'h00);
    word_seen_nxt = word_seen_r;
    prog_nxt      = prog_r;
    if (!zero_seen_nxt && !word_seen_r) begin
      if (payload_byte == word_char(prog_r)) begin
        if (prog_r == PROG_W'(WORD_LEN - 1)) begin
          word_seen_nxt = 1'b1;
          prog_nxt      = '0;
        end else begin
          prog_nxt = prog_r + 1'b1;
        end
      end else if (payload_byte == word_char('0)) begin
        prog_nxt = PROG_W'(1);
      end else begin
        prog_nxt = '0;
      end
    end

    lead           = {head_nxt[0], head_nxt[1], head_nxt[2], head_nxt[3]};
    magic_len_ok   = CMP_WIDTH'(count_nxt) >= CMP_WIDTH'(cfg.magic_min_length);
    listing_len_ok = CMP_WIDTH'(count_nxt) >= CMP_WIDTH'(cfg.listing_min_length);

    rec.flow_start  = flow_start;
    rec.magic_hit   = magic_len_ok &&
                      (magic_sig_hit(lead) || ((lead == XML_LEAD) && !word_seen_nxt));
    rec.listing_hit = listing_len_ok && listing_hit(head_nxt);
    rec.port_hit    = is_tcp &&
                      ((source_port == cfg.data_port) || (dest_port == cfg.data_port));
    rec_valid       = accept && last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      prog_r      <= '0;
      word_seen_r <= 1'b0;
      zero_seen_r <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        head_r      <= '0;
        count_r     <= '0;
        prog_r      <= '0;
        word_seen_r <= 1'b0;
        zero_seen_r <= 1'b0;
      end else begin
        head_r      <= head_nxt;
        count_r     <= count_nxt;
        prog_r      <= prog_nxt;
        word_seen_r <= word_seen_nxt;
        zero_seen_r <= zero_seen_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/ftpc_queue.sv -----
// Short record queue between the front end and the verdict stage.
// Depends on ftpc_pkg for the record type and depth.
module ftpc_queue import ftpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pkt_rec_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output pkt_rec_t pop_data
);

  pkt_rec_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/ftpc_back.sv -----
// Verdict stage: ranks the tests of one packet record and holds the result beat.
// Depends on ftpc_pkg for the record and reason types.
module ftpc_back import ftpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  pkt_rec_t q_rec,
  output logic     q_pop,
  input  logic     out_pop,
  output logic     out_valid,
  output logic     out_detected,
  output reason_t  out_reason
);

  logic    out_valid_r, out_valid_nxt;
  logic    detected_r;
  reason_t reason_r;
  reason_t reason_nxt;
  logic    take;

  assign take = q_valid && (!out_valid_r || out_pop);
  assign q_pop = take;

  always_comb begin
    reason_nxt = REASON_NONE;
    if (q_rec.flow_start) begin
      if (q_rec.magic_hit) begin
        reason_nxt = REASON_MAGIC;
      end else if (q_rec.listing_hit) begin
        reason_nxt = REASON_LISTING;
      end else if (q_rec.port_hit) begin
        reason_nxt = REASON_PORT;
      end
    end
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      reason_r   <= reason_nxt;
      detected_r <= (reason_nxt != REASON_NONE);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_detected = detected_r;
  assign out_reason   = reason_r;

endmodule

// ----- rtl/core/ftp_data_payload_classifier.sv -----
// FTP data payload classifier: one payload byte per push beat, one verdict beat per packet
// on its last byte; takes a byte every cycle while full is low; the verdict passes from the
// front end into the record queue, then the verdict register; full rises only when three
// verdicts wait (two records in the queue and one held result beat).
// Verdict ranks file magic, then listing line, then known data port, gated by flow start.
// Depends on ftpc_pkg, ftpc_front, ftpc_queue and ftpc_back; holds the APB config registers.
module ftp_data_payload_classifier import ftpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_payload_byte,
  input  logic                 in_last_byte,
  input  logic                 in_is_tcp,
  input  logic [15:0]          in_source_port,
  input  logic [15:0]          in_dest_port,
  input  logic                 in_flow_start,
  output logic                 empty,
  input  logic                 pop,
  output logic                 out_detected,
  output logic [1:0]           out_reason,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  cfg_t                  cfg_r, cfg_nxt;
  logic [REG_ADDR_W-1:0] reg_idx;
  logic                  cfg_wr;
  logic                  accept;
  logic                  rec_valid;
  pkt_rec_t              rec;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  pkt_rec_t              q_rec;
  logic                  out_valid;
  reason_t               reason;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_DATA_PORT:   cfg_nxt.data_port          = pwdata[CFG_WIDTH-1:0];
        REG_MAGIC_MIN:   cfg_nxt.magic_min_length   = pwdata[CFG_WIDTH-1:0];
        REG_LISTING_MIN: cfg_nxt.listing_min_length = pwdata[CFG_WIDTH-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
    case (reg_idx)
      REG_DATA_PORT:   prdata = PDATA_W'(cfg_r.data_port);
      REG_MAGIC_MIN:   prdata = PDATA_W'(cfg_r.magic_min_length);
      REG_LISTING_MIN: prdata = PDATA_W'(cfg_r.listing_min_length);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_port          <= RST_DATA_PORT;
      cfg_r.magic_min_length   <= RST_MAGIC_MIN;
      cfg_r.listing_min_length <= RST_LISTING_MIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  ftpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .payload_byte (in_payload_byte),
    .last_byte    (in_last_byte),
    .is_tcp       (in_is_tcp),
    .source_port  (in_source_port),
    .dest_port    (in_dest_port),
    .flow_start   (in_flow_start),
    .cfg          (cfg_r),
    .rec_valid    (rec_valid),
    .rec          (rec)
  );

  ftpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_valid),
    .push_data (rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_rec)
  );

  ftpc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_rec        (q_rec),
    .q_pop        (q_pop),
    .out_pop      (pop),
    .out_valid    (out_valid),
    .out_detected (out_detected),
    .out_reason   (reason)
  );

  assign empty      = !out_valid;
  assign out_reason = reason;

endmodule
